FILE: hdl/hrfl_pkg.sv
// ----------------------------------------------------------------------------
// hrfl_pkg
// shared constants, codes and control structs of the hex record flash loader
// ----------------------------------------------------------------------------
package hrfl_pkg;

    localparam int MAX_DATA_BYTES = 32;
    localparam int HDR_BYTES      = 4;
    localparam int DATA_WORDS     = (MAX_DATA_BYTES + 1) / 2;
    localparam int WORD_IDX_W     = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam int POS_MAX        = MAX_DATA_BYTES + HDR_BYTES;
    localparam int POS_W          = $clog2(POS_MAX + 1);
    localparam int CNT_W          = (POS_W > 8) ? POS_W : 8;
    localparam int NW_W           = $clog2(DATA_WORDS + 1);

    // input selector
    localparam logic [1:0] MODE_BYTE   = 2'd0;
    localparam logic [1:0] MODE_FAIL   = 2'd1;
    localparam logic [1:0] MODE_MANUAL = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    // result kind
    localparam logic [1:0] KIND_ERASE   = 2'd0;
    localparam logic [1:0] KIND_PROGRAM = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // record status
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_CHECKSUM = 2'd1;
    localparam logic [1:0] STAT_TYPE     = 2'd2;
    localparam logic [1:0] STAT_LONG     = 2'd3;

    // record types
    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EOF     = 8'h01;
    localparam logic [7:0] REC_EXT_LIN = 8'h04;

    // flash window and sectors
    localparam logic [31:0] FLASH_LO     = 32'h0030_0000;
    localparam logic [31:0] FLASH_HI     = 32'h0033_7FFF;
    localparam int          SECTOR_SHIFT = 15;
    localparam logic [7:0]  SECTOR_TOP   = 8'h80;
    localparam logic [7:0]  MANUAL_KEEP  = 8'hFE;

    typedef struct packed {
        logic add_byte;
        logic store_byte;
        logic fail_clear;
        logic eval;
        logic emit_erase;
        logic emit_word;
        logic emit_status;
        logic emit_manual;
    } dp_cmd_t;

    typedef struct packed {
        logic            out_free;
        logic            need_erase;
        logic [NW_W-1:0] word_count;
        logic            last_word;
    } dp_sts_t;

endpackage

FILE: hdl/hrfl_ram.sv
// ----------------------------------------------------------------------------
// hrfl_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module hrfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/hrfl_datapath.sv
// ----------------------------------------------------------------------------
// hrfl_datapath
// record buffer, checksum, header, sector tracking and result register
// ----------------------------------------------------------------------------
module hrfl_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  hrfl_pkg::dp_cmd_t cmd,
    output hrfl_pkg::dp_sts_t sts,
    input  logic [7:0]        in_byte,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [1:0]        out_kind,
    output logic [31:0]       out_addr,
    output logic [15:0]       out_value,
    output logic [7:0]        out_sectors,
    output logic [1:0]        out_status,
    output logic              out_last
);

    localparam int PW = hrfl_pkg::POS_W;
    localparam int WW = hrfl_pkg::WORD_IDX_W;
    localparam int NW = hrfl_pkg::NW_W;
    localparam int CW = hrfl_pkg::CNT_W;

    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    count_reg, count_next;
    logic [15:0]   addr_reg, addr_next;
    logic [7:0]    type_reg, type_next;
    logic          ovf_reg, ovf_next;
    logic [15:0]   upper_reg, upper_next;
    logic [7:0]    erased_reg, erased_next;
    logic [7:0]    mask_reg, mask_next;
    logic [WW-1:0] word_idx_reg, word_idx_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_kind_reg, out_kind_next;
    logic [31:0]   out_addr_reg, out_addr_next;
    logic [15:0]   out_value_reg, out_value_next;
    logic [7:0]    out_sectors_reg, out_sectors_next;
    logic [1:0]    out_status_reg, out_status_next;
    logic          out_last_reg, out_last_next;

    logic [PW-1:0] byte_idx;
    logic          idx_fits;
    logic          ram_we_even;
    logic          ram_we_odd;
    logic [7:0]    rdata_even;
    logic [7:0]    rdata_odd;

    logic [PW-1:0] have;
    logic [CW-1:0] have_ext;
    logic [CW-1:0] cnt;
    logic [NW-1:0] nw;
    logic [31:0]   base_addr;
    logic [31:0]   addr_off;
    logic          in_range;
    logic [2:0]    sector_num;
    logic [7:0]    sector_bit;
    logic          sum_ok;
    logic          data_ok;
    logic [1:0]    rec_status;
    logic [7:0]    b0;
    logic [7:0]    b1;
    logic [7:0]    manual_mask;

    // buffer write side
    assign byte_idx    = pos_reg - PW'(hrfl_pkg::HDR_BYTES);
    assign idx_fits    = (pos_reg >= PW'(hrfl_pkg::HDR_BYTES))
                       && (byte_idx < PW'(hrfl_pkg::MAX_DATA_BYTES));
    assign ram_we_even = cmd.store_byte && idx_fits && !byte_idx[0];
    assign ram_we_odd  = cmd.store_byte && idx_fits && byte_idx[0];

    hrfl_ram #(
        .WIDTH (8),
        .DEPTH (hrfl_pkg::DATA_WORDS)
    ) u_ram_even (
        .clk   (clk),
        .we    (ram_we_even),
        .waddr (byte_idx[WW:1]),
        .wdata (in_byte),
        .raddr (word_idx_next),
        .rdata (rdata_even)
    );

    hrfl_ram #(
        .WIDTH (8),
        .DEPTH (hrfl_pkg::DATA_WORDS)
    ) u_ram_odd (
        .clk   (clk),
        .we    (ram_we_odd),
        .waddr (byte_idx[WW:1]),
        .wdata (in_byte),
        .raddr (word_idx_next),
        .rdata (rdata_odd)
    );

    // record evaluation
    assign have       = (pos_reg > PW'(hrfl_pkg::HDR_BYTES)) ? byte_idx : '0;
    assign have_ext   = CW'(have);
    assign cnt        = (CW'(count_reg) > have_ext) ? have_ext : CW'(count_reg);
    assign nw         = NW'(cnt >> 1);
    assign base_addr  = {upper_reg, addr_reg};
    assign addr_off   = base_addr - hrfl_pkg::FLASH_LO;
    assign in_range   = (base_addr >= hrfl_pkg::FLASH_LO) && (base_addr <= hrfl_pkg::FLASH_HI);
    assign sector_num = addr_off[hrfl_pkg::SECTOR_SHIFT+2:hrfl_pkg::SECTOR_SHIFT];
    assign sector_bit = hrfl_pkg::SECTOR_TOP >> sector_num;
    assign sum_ok     = (sum_reg == 8'd0);
    assign data_ok    = !ovf_reg && sum_ok && (type_reg == hrfl_pkg::REC_DATA) && in_range;
    assign b0         = (have >= PW'(1)) ? rdata_even : 8'd0;
    assign b1         = (have >= PW'(2)) ? rdata_odd : 8'd0;
    assign manual_mask = mask_reg & hrfl_pkg::MANUAL_KEEP;

    always_comb
    begin
        if (ovf_reg)
        begin
            rec_status = hrfl_pkg::STAT_LONG;
        end
        else if (!sum_ok)
        begin
            rec_status = hrfl_pkg::STAT_CHECKSUM;
        end
        else if ((type_reg == hrfl_pkg::REC_DATA) || (type_reg == hrfl_pkg::REC_EOF)
                 || (type_reg == hrfl_pkg::REC_EXT_LIN))
        begin
            rec_status = hrfl_pkg::STAT_OK;
        end
        else
        begin
            rec_status = hrfl_pkg::STAT_TYPE;
        end
    end

    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.need_erase = data_ok && ((sector_bit & erased_reg) == 8'd0);
    assign sts.word_count = data_ok ? nw : '0;
    assign sts.last_word  = (NW'(word_idx_reg) + NW'(1)) == sts.word_count;

    always_comb
    begin
        pos_next         = pos_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        addr_next        = addr_reg;
        type_next        = type_reg;
        ovf_next         = ovf_reg;
        upper_next       = upper_reg;
        erased_next      = erased_reg;
        mask_next        = mask_reg;
        word_idx_next    = word_idx_reg;
        out_valid_next   = out_valid_reg;
        out_kind_next    = out_kind_reg;
        out_addr_next    = out_addr_reg;
        out_value_next   = out_value_reg;
        out_sectors_next = out_sectors_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;

        if (cfg_wr_en)
        begin
            mask_next = cfg_wr_data;
        end

        if (cmd.add_byte)
        begin
            sum_next = sum_reg + in_byte;
        end

        if (cmd.store_byte)
        begin
            if (pos_reg < PW'(hrfl_pkg::HDR_BYTES))
            begin
                case (pos_reg[1:0])
                    2'd0:    count_next = in_byte;
                    2'd1:    addr_next[15:8] = in_byte;
                    2'd2:    addr_next[7:0] = in_byte;
                    default: type_next = in_byte;
                endcase
            end
            else if (!idx_fits)
            begin
                ovf_next = 1'b1;
            end
            if (pos_reg < PW'(hrfl_pkg::POS_MAX))
            begin
                pos_next = pos_reg + PW'(1);
            end
        end

        if (cmd.fail_clear)
        begin
            erased_next = 8'd0;
        end

        if (cmd.eval && !ovf_reg && sum_ok)
        begin
            if (type_reg == hrfl_pkg::REC_EOF)
            begin
                erased_next = 8'd0;
            end
            if (type_reg == hrfl_pkg::REC_EXT_LIN)
            begin
                upper_next = {b0, b1};
            end
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.emit_erase)
        begin
            erased_next      = erased_reg | sector_bit;
            out_valid_next   = 1'b1;
            out_kind_next    = hrfl_pkg::KIND_ERASE;
            out_addr_next    = 32'd0;
            out_value_next   = 16'd0;
            out_sectors_next = sector_bit;
            out_status_next  = hrfl_pkg::STAT_OK;
            out_last_next    = 1'b0;
        end

        if (cmd.emit_word)
        begin
            word_idx_next    = word_idx_reg + WW'(1);
            out_valid_next   = 1'b1;
            out_kind_next    = hrfl_pkg::KIND_PROGRAM;
            out_addr_next    = base_addr + 32'(word_idx_reg);
            out_value_next   = {rdata_even, rdata_odd};
            out_sectors_next = 8'd0;
            out_status_next  = hrfl_pkg::STAT_OK;
            out_last_next    = 1'b0;
        end

        if (cmd.emit_status)
        begin
            pos_next         = '0;
            sum_next         = 8'd0;
            count_next       = 8'd0;
            addr_next        = 16'd0;
            type_next        = 8'd0;
            ovf_next         = 1'b0;
            word_idx_next    = '0;
            out_valid_next   = 1'b1;
            out_kind_next    = hrfl_pkg::KIND_STATUS;
            out_addr_next    = 32'd0;
            out_value_next   = 16'd0;
            out_sectors_next = 8'd0;
            out_status_next  = rec_status;
            out_last_next    = 1'b1;
        end

        if (cmd.emit_manual)
        begin
            erased_next      = erased_reg | manual_mask;
            out_valid_next   = 1'b1;
            out_kind_next    = hrfl_pkg::KIND_ERASE;
            out_addr_next    = 32'd0;
            out_value_next   = 16'd0;
            out_sectors_next = manual_mask;
            out_status_next  = hrfl_pkg::STAT_OK;
            out_last_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            sum_reg       <= 8'd0;
            count_reg     <= 8'd0;
            addr_reg      <= 16'd0;
            type_reg      <= 8'd0;
            ovf_reg       <= 1'b0;
            upper_reg     <= 16'd0;
            erased_reg    <= 8'd0;
            mask_reg      <= 8'd0;
            word_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            type_reg      <= type_next;
            ovf_reg       <= ovf_next;
            upper_reg     <= upper_next;
            erased_reg    <= erased_next;
            mask_reg      <= mask_next;
            word_idx_reg  <= word_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg    <= out_kind_next;
        out_addr_reg    <= out_addr_next;
        out_value_reg   <= out_value_next;
        out_sectors_reg <= out_sectors_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_addr    = out_addr_reg;
    assign out_value   = out_value_reg;
    assign out_sectors = out_sectors_reg;
    assign out_status  = out_status_reg;
    assign out_last    = out_last_reg;

endmodule

FILE: hdl/hrfl_ctrl.sv
// ----------------------------------------------------------------------------
// hrfl_ctrl
// request decode and result sequencing state machine
// ----------------------------------------------------------------------------
module hrfl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_mode,
    input  logic              in_last,
    output logic              in_ready,
    input  hrfl_pkg::dp_sts_t sts,
    output hrfl_pkg::dp_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EVAL   = 6'b000010,
        ST_ERASE  = 6'b000100,
        ST_WORD   = 6'b001000,
        ST_STATUS = 6'b010000,
        ST_MANUAL = 6'b100000
    } ctl_state_t;

    ctl_state_t state_reg, state_next;
    logic       accept;
    logic       has_words;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign has_words = (sts.word_count != '0);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_mode)
                        hrfl_pkg::MODE_BYTE:
                        begin
                            cmd.add_byte = 1'b1;
                            if (in_last)
                            begin
                                state_next = ST_EVAL;
                            end
                            else
                            begin
                                cmd.store_byte = 1'b1;
                            end
                        end
                        hrfl_pkg::MODE_FAIL:   cmd.fail_clear = 1'b1;
                        hrfl_pkg::MODE_MANUAL: state_next = ST_MANUAL;
                        default:               state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.need_erase)
                begin
                    state_next = ST_ERASE;
                end
                else if (has_words)
                begin
                    state_next = ST_WORD;
                end
                else
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_ERASE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_erase = 1'b1;
                    state_next     = has_words ? ST_WORD : ST_STATUS;
                end
            end
            ST_WORD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_word = 1'b1;
                    if (sts.last_word)
                    begin
                        state_next = ST_STATUS;
                    end
                end
            end
            ST_STATUS:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_MANUAL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_manual = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/hex_record_flash_loader.sv
// ----------------------------------------------------------------------------
// hex_record_flash_loader
// binary hex record parser that issues flash erase and program requests
// ----------------------------------------------------------------------------
// Record bytes, failure reports and manual erase requests enter on the slave
// stream, one per cycle while the loader is idle; bytes before the checksum
// byte produce nothing. The checksum byte (tlast) starts evaluation: a
// decision state, then each result in turn through the output register
// (an optional sector erase, one program request per data word, then the
// record status); the input is held off until the record status is loaded,
// and a manual erase holds it off until its erase result is loaded, both
// also through any backpressure. Data bytes live in two small rams (even
// and odd bytes) read one word per cycle during emission while the output
// register is free; no clearing pass follows reset.
module hex_record_flash_loader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] record_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    input  logic        s_axis_tlast,   // end_of_record
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] word_address, [47:32] word_value,
                                        // [55:48] erase_sectors, [57:56] status
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,   // last_result
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data     // manual_erase_mask
);

    hrfl_pkg::dp_cmd_t cmd;
    hrfl_pkg::dp_sts_t sts;

    logic [31:0] out_addr;
    logic [15:0] out_value;
    logic [7:0]  out_sectors;
    logic [1:0]  out_status;

    hrfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_mode  (s_axis_tuser),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hrfl_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_byte     (s_axis_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_kind    (m_axis_tuser),
        .out_addr    (out_addr),
        .out_value   (out_value),
        .out_sectors (out_sectors),
        .out_status  (out_status),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_status, out_sectors, out_value, out_addr};

    // at most one result loaded per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_erase, cmd.emit_word, cmd.emit_status, cmd.emit_manual}))
    else $error("more than one result loaded in a cycle");

    // results only go into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_erase || cmd.emit_word || cmd.emit_status || cmd.emit_manual)
        |-> sts.out_free)
    else $error("result loaded over a pending one");

    // a checksum byte makes the loader busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == hrfl_pkg::MODE_BYTE)
         && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken during record evaluation");

    // a program request needs a nonzero word count
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_word |-> (sts.word_count != '0))
    else $error("program request without data words");

endmodule
